// ===== src/byte_escape_encoder_core_defines.svh =====
// Assertion macros shared by the escape encoder checker.
// Needs nothing else; included by the checker file only.
`ifndef BYTE_ESCAPE_ENCODER_CORE_DEFINES_SVH
`define BYTE_ESCAPE_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BEE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BEE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bee_pkg.sv =====
// Shared types and constants for the byte escape encoder.
// No dependencies; used by every module of the block.
`default_nettype none

package bee_pkg;

  // Raw capacity register width, port and result field widths, queue depth
  localparam int CAP_CFG_W = 13;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_OFF_W = 12;
  localparam int OUT_LEN_W = 32;
  localparam int QDEPTH = 2;

  // Register map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_CAPACITY = 1'b0,
    REG_START_LENGTH    = 1'b1
  } cfg_reg_t;

  // Characters of the escape sequences
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_R      = 8'h72;

  // Byte class boundaries
  localparam logic [7:0] BYTE_NUL     = 8'h00;
  localparam logic [7:0] BYTE_BS      = 8'h08;
  localparam logic [7:0] BYTE_TAB     = 8'h09;
  localparam logic [7:0] BYTE_LF      = 8'h0A;
  localparam logic [7:0] BYTE_VT      = 8'h0B;
  localparam logic [7:0] BYTE_FF      = 8'h0C;
  localparam logic [7:0] BYTE_CR      = 8'h0D;
  localparam logic [7:0] BYTE_SO      = 8'h0E;
  localparam logic [7:0] BYTE_US      = 8'h1F;
  localparam logic [7:0] BYTE_DEL     = 8'h7F;

  // Lower-case hex digit table, index 0 in the lowest byte
  localparam logic [15:0][7:0] HEX_DIGITS = {
    8'h66, 8'h65, 8'h64, 8'h63, 8'h62, 8'h61, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
  };

  // One classified byte, ready for serialisation
  typedef struct packed {
    logic [3:0][7:0]       chars;
    logic [1:0]            last_idx;
    logic [OUT_OFF_W-1:0]  base;
    logic                  fits;
    logic [OUT_LEN_W-1:0]  length;
    logic                  full;
  } seq_entry_t;

endpackage

`default_nettype wire

// ===== src/bee_front.sv =====
// Front end: configuration registers, byte classification and buffer state.
// Depends on bee_pkg; feeds bee_queue.
`default_nettype none

module bee_front #(
  parameter int MAX_CAPACITY = 4096,
  parameter int LENGTH_BITS  = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [bee_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bee_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              push,
  input  wire logic [7:0]                        source_byte,
  input  wire logic                              first_byte,
  output bee_pkg::seq_entry_t                    entry
);

  // Offset never exceeds the 13-bit capacity register nor MAX_CAPACITY
  localparam int OFF_W = (MAX_CAPACITY > 8191) ? 13 : $clog2(MAX_CAPACITY + 1);
  localparam logic [31:0] CAP_RESET = (MAX_CAPACITY < 4096) ? 32'(MAX_CAPACITY) : 32'd4096;

  logic [OFF_W-1:0]       cap_r;
  logic [LENGTH_BITS-1:0] start_len_r;
  logic [OFF_W-1:0]       offset_r, offset_nxt;
  logic [LENGTH_BITS-1:0] total_r, total_nxt;

  logic [31:0]            cap_w, cap_clamp;
  logic [3:0][7:0]        chars;
  logic [1:0]             last_idx;
  logic [2:0]             n;
  logic [OFF_W-1:0]       base0, base;
  logic [OFF_W:0]         end_pos;
  logic                   fits;
  logic [LENGTH_BITS-1:0] len0;
  logic [LENGTH_BITS:0]   len_sum;
  logic [63:0]            len_wide;
  logic [31:0]            base_wide;

  // Capacity above the maximum acts as the maximum
  assign cap_w     = 32'(cfg_data[bee_pkg::CAP_CFG_W-1:0]);
  assign cap_clamp = (cap_w > 32'(MAX_CAPACITY)) ? 32'(MAX_CAPACITY) : cap_w;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET[OFF_W-1:0];
      start_len_r <= '0;
    end else if (cfg_we) begin
      case (bee_pkg::cfg_reg_t'(cfg_index))
        bee_pkg::REG_BUFFER_CAPACITY: cap_r       <= cap_clamp[OFF_W-1:0];
        bee_pkg::REG_START_LENGTH:    start_len_r <= LENGTH_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // Classify the byte into its escape sequence
  always_comb begin
    chars    = '0;
    last_idx = 2'd0;
    if (source_byte == bee_pkg::BYTE_NUL) begin
      chars[0] = bee_pkg::CH_BSLASH;
      chars[1] = bee_pkg::CH_ZERO;
      last_idx = 2'd1;
    end else if (source_byte >= bee_pkg::BYTE_TAB && source_byte <= bee_pkg::BYTE_CR) begin
      chars[0] = bee_pkg::CH_BSLASH;
      last_idx = 2'd1;
      case (source_byte)
        bee_pkg::BYTE_TAB: chars[1] = bee_pkg::CH_T;
        bee_pkg::BYTE_LF:  chars[1] = bee_pkg::CH_N;
        bee_pkg::BYTE_VT:  chars[1] = bee_pkg::CH_V;
        bee_pkg::BYTE_FF:  chars[1] = bee_pkg::CH_F;
        default:           chars[1] = bee_pkg::CH_R;
      endcase
    end else if (source_byte == bee_pkg::CH_BSLASH || source_byte == bee_pkg::CH_QUOTE) begin
      chars[0] = bee_pkg::CH_BSLASH;
      chars[1] = source_byte;
      last_idx = 2'd1;
    end else if (source_byte <= bee_pkg::BYTE_BS
                 || (source_byte >= bee_pkg::BYTE_SO && source_byte <= bee_pkg::BYTE_US)
                 || source_byte >= bee_pkg::BYTE_DEL) begin
      chars[0] = bee_pkg::CH_BSLASH;
      chars[1] = bee_pkg::CH_X;
      chars[2] = bee_pkg::HEX_DIGITS[source_byte[7:4]];
      chars[3] = bee_pkg::HEX_DIGITS[source_byte[3:0]];
      last_idx = 2'd3;
    end else begin
      chars[0] = source_byte;
    end
  end

  assign n = 3'(last_idx) + 3'd1;

  // Offset: restart, clamp to capacity, then place or drop the sequence
  assign base0   = first_byte ? '0 : offset_r;
  assign base    = (base0 > cap_r) ? cap_r : base0;
  assign end_pos = {1'b0, base} + (OFF_W + 1)'(n);
  assign fits    = end_pos <= {1'b0, cap_r};
  assign offset_nxt = fits ? end_pos[OFF_W-1:0] : cap_r;

  // Saturating logical length
  assign len0      = first_byte ? start_len_r : total_r;
  assign len_sum   = {1'b0, len0} + (LENGTH_BITS + 1)'(n);
  assign total_nxt = len_sum[LENGTH_BITS] ? '1 : len_sum[LENGTH_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      total_r  <= '0;
    end else if (push) begin
      offset_r <= offset_nxt;
      total_r  <= total_nxt;
    end
  end

  // Entry for the queue
  assign len_wide  = 64'(total_nxt);
  assign base_wide = 32'(base);
  always_comb begin
    entry.chars    = chars;
    entry.last_idx = last_idx;
    entry.base     = base_wide[bee_pkg::OUT_OFF_W-1:0];
    entry.fits     = fits;
    entry.length   = len_wide[bee_pkg::OUT_LEN_W-1:0];
    entry.full     = (offset_nxt == cap_r);
  end

endmodule

`default_nettype wire

// ===== src/bee_queue.sv =====
// Two-entry queue between the classifier and the serialiser.
// Depends on bee_pkg for the entry type.
`default_nettype none

module bee_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire bee_pkg::seq_entry_t  push_entry,
  input  wire logic                 pop,
  output bee_pkg::seq_entry_t       head,
  output logic                      head_valid,
  output logic                      can_push
);

  localparam int PTR_W = $clog2(bee_pkg::QDEPTH);
  localparam int CNT_W = $clog2(bee_pkg::QDEPTH + 1);

  bee_pkg::seq_entry_t slots [bee_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head       = slots[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign can_push   = (count_r != CNT_W'(bee_pkg::QDEPTH));

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (!push && pop) count_nxt = count_r - CNT_W'(1);
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr_r] <= push_entry;
  end

endmodule

`default_nettype wire

// ===== src/bee_back.sv =====
// Back end: serialises one queued sequence into single-character results.
// Depends on bee_pkg; reads the head of bee_queue.
`default_nettype none

module bee_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire bee_pkg::seq_entry_t                head,
  input  wire logic                               head_valid,
  output logic                                    pop,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [7:0]                              out_char,
  output logic [bee_pkg::OUT_OFF_W-1:0]           out_offset,
  output logic                                    out_char_valid,
  output logic                                    out_last_of_run,
  output logic [bee_pkg::OUT_LEN_W-1:0]           out_logical_length,
  output logic                                    out_buffer_full
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic       load, last;

  logic [7:0]                    char_r;
  logic [bee_pkg::OUT_OFF_W-1:0] offset_r;
  logic                          wr_r, last_r, full_r;
  logic [bee_pkg::OUT_LEN_W-1:0] length_r;

  // Load the output register whenever it is free or being drained
  assign load = head_valid && (!valid_r || out_ready);
  assign last = (idx_r == head.last_idx);
  assign pop  = load && last;

  always_comb begin
    idx_nxt = idx_r;
    if (load) idx_nxt = last ? 2'd0 : idx_r + 2'd1;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Result payload; dropped characters show offset zero
  always_ff @(posedge clk) begin
    if (load) begin
      char_r   <= head.chars[idx_r];
      offset_r <= head.fits ? head.base + bee_pkg::OUT_OFF_W'(idx_r) : '0;
      wr_r     <= head.fits;
      last_r   <= last;
      length_r <= head.length;
      full_r   <= head.full;
    end
  end

  assign out_valid          = valid_r;
  assign out_char           = char_r;
  assign out_offset         = offset_r;
  assign out_char_valid     = wr_r;
  assign out_last_of_run    = last_r;
  assign out_logical_length = length_r;
  assign out_buffer_full    = full_r;

endmodule

`default_nettype wire

// ===== src/byte_escape_encoder_core.sv =====
// Top level of the C-style byte escape encoder.
// Depends on bee_pkg, bee_front, bee_queue and bee_back.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_source_byte, in_first_byte
//  out     | output    | out_valid / out_ready | out_char .. out_buffer_full
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A byte yields one result per character: 1 for a verbatim byte, 2 for a
// two-character escape, 4 for \xHH; the one-character serialiser sets this.
// The classifier takes a byte per cycle into a two-entry queue and stalls
// only when that queue is full. Results pass through the queue and then the
// output register. Synchronous active-low reset; cfg_ready is always high.
`default_nettype none

module byte_escape_encoder_core #(
  parameter int MAX_CAPACITY = 4096,
  parameter int LENGTH_BITS  = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bee_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bee_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [7:0]                         in_source_byte,
  input  wire logic                               in_first_byte,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [7:0]                              out_char,
  output logic [bee_pkg::OUT_OFF_W-1:0]           out_offset,
  output logic                                    out_char_valid,
  output logic                                    out_last_of_run,
  output logic [bee_pkg::OUT_LEN_W-1:0]           out_logical_length,
  output logic                                    out_buffer_full
);

  bee_pkg::seq_entry_t new_entry, head;
  logic push, pop, head_valid, can_push;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_push;
  assign push      = in_valid && can_push;

  // Classification and buffer state
  bee_front #(
    .MAX_CAPACITY (MAX_CAPACITY),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .source_byte (in_source_byte),
    .first_byte  (in_first_byte),
    .entry       (new_entry)
  );

  // Decoupling queue
  bee_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (new_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .can_push   (can_push)
  );

  // Serialiser and output register
  bee_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .head_valid         (head_valid),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char           (out_char),
    .out_offset         (out_offset),
    .out_char_valid     (out_char_valid),
    .out_last_of_run    (out_last_of_run),
    .out_logical_length (out_logical_length),
    .out_buffer_full    (out_buffer_full)
  );

endmodule

`default_nettype wire

// ===== src/bee_checker.sv =====
// Port-level checker for the escape encoder, bound to the top level.
// Depends on bee_pkg and byte_escape_encoder_core_defines.svh.
`default_nettype none
`include "byte_escape_encoder_core_defines.svh"

module bee_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [7:0]                         out_char,
  input wire logic [bee_pkg::OUT_OFF_W-1:0]      out_offset,
  input wire logic                               out_char_valid,
  input wire logic                               out_last_of_run,
  input wire logic [bee_pkg::OUT_LEN_W-1:0]      out_logical_length,
  input wire logic                               out_buffer_full
);

  logic out_xact;
  assign out_xact = out_valid && out_ready;

  // A stalled result keeps its character
  `BEE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_char), "stalled result changed")

  // Dropped characters report offset zero
  `BEE_ASSERT_NOW(a_drop_offset, clk, rst_n, out_valid && !out_char_valid, out_offset == '0, "dropped character with non-zero offset")

  // The rest of a run follows with no gap
  `BEE_ASSERT_NEXT(a_run_cont, clk, rst_n, out_xact && !out_last_of_run, out_valid, "gap inside an escape run")

  // Per-byte fields stay the same across a run
  `BEE_ASSERT_NEXT(a_run_fields, clk, rst_n, out_xact && !out_last_of_run, $stable(out_logical_length) && $stable(out_buffer_full) && $stable(out_char_valid), "run fields changed within a byte")

endmodule

bind byte_escape_encoder_core bee_checker u_bee_checker (.*);

`default_nettype wire
